/* sv/ola_time_stretch_top_defines.svh */
// assertion macros for the overlap-add time stretch block
// no dependencies; included by the top level, which provides clk and rst_n
`ifndef OLA_TIME_STRETCH_TOP_DEFINES_SVH
`define OLA_TIME_STRETCH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define OTS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define OTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OTS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define OTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/ots_pkg.sv */
// shared types and constants of the overlap-add time stretch block
// no dependencies
`default_nettype none

package ots_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int FACTOR_W      = 15;
    localparam int OPC_W         = 2;

    localparam int MAX_SAMPLES_DEF = 65536;
    localparam int GRAIN_MAX_DEF   = 4096;
    localparam int GRAIN_MIN       = 256;

    localparam int FACTOR_LO     = 1024;
    localparam int FACTOR_HI     = 16384;
    localparam int FACTOR_RESET  = 4096;
    localparam int MIN_OUT       = 8;

    // fixed-point shifts and rounding terms
    localparam int START_SHIFT   = 13;
    localparam int U_SHIFT       = 17;
    localparam int Q16           = 16;
    localparam int LEN_SHIFT     = 12;
    localparam int ROUND_LEN     = 2048;
    localparam int S15_SHIFT     = 13;
    localparam int ROUND_S       = 4096;
    localparam int W_SHIFT       = 15;
    localparam int ROUND_W       = 16384;
    localparam int OUT_SHIFT     = 15;
    localparam int ROUND_OUT     = 16384;
    localparam int S_MAX         = 268435456;
    localparam int S_W           = 29;
    localparam int TRUNC_BIAS    = 65535;

    localparam int U_W           = 17;
    localparam int WIN_W         = 16;
    localparam int MA_W          = 32;
    localparam int MB_W          = 18;
    localparam int MP_W          = 50;
    localparam int ACC_W         = 35;
    localparam int OUT_MAX       = 32767;
    localparam int OUT_MIN       = -32768;

    // sine polynomial, Q28, highest power first
    localparam int HC0 = 43068;
    localparam int HC1 = -1256749;
    localparam int HC2 = 21392327;
    localparam int HC3 = -173399667;
    localparam int HC4 = 421657428;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_READ    = 2'd1,
        OP_RESTART = 2'd2
    } opcode_t;

    function automatic logic signed [MA_W-1:0] horner_coef(input logic [2:0] step);
        logic signed [MA_W-1:0] c;
        case (step)
            3'd1:    c = MA_W'(HC1);
            3'd2:    c = MA_W'(HC2);
            3'd3:    c = MA_W'(HC3);
            3'd4:    c = MA_W'(HC4);
            default: c = MA_W'(HC0);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/ola_time_stretch_top.sv */
// overlap-add time stretch top level; uses ots_pkg, ots_ram and the assertion header
// load and restart are taken in idle, one item in flight at a time. a stretched read runs,
// for each covering grain (1 to 3 grains), the shared radix-2 divider for grain start and
// window phase, then the multiplier sequence; short input and past end skip the grains;
// a held output adds its stall. reset: async, clears control only
`default_nettype none
`include "ola_time_stretch_top_defines.svh"

module ola_time_stretch_top #(
    parameter int MAX_SAMPLES = ots_pkg::MAX_SAMPLES_DEF,
    parameter int GRAIN_MAX   = ots_pkg::GRAIN_MAX_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ots_pkg::SAMPLE_W-1:0]  s_tdata,   // in_sample
    input  wire logic [ots_pkg::OPC_W-1:0]     s_tuser,   // opcode
    // output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [ots_pkg::SAMPLE_W-1:0]  m_tdata,   // out_sample
    output logic                               m_tlast,   // is_last
    output logic                               m_tuser,   // past_end
    // stretch factor register write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ots_pkg::FACTOR_W-1:0]  cfg_data
);

    import ots_pkg::*;

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int NW    = $clog2(MAX_SAMPLES + 1);
    localparam int PW    = NW + 3;                       // output length up to 4*N
    localparam int GW    = $clog2(GRAIN_MAX + 1);
    localparam int DDW   = FACTOR_W + 1;                 // divisor: 2*factor or grain - 1
    localparam int DNW_A = PW + START_SHIFT + 1;         // 2*start*4096 + factor
    localparam int DNW_B = GW - 1 + U_SHIFT;             // 2*d*65536
    localparam int DNW   = (DNW_A > DNW_B) ? DNW_A : DNW_B;
    localparam int CW    = $clog2(DNW + 1);
    localparam int TW    = MP_W - Q16;

    // multiply sequence for one grain: window polynomial then the weighted sample
    localparam logic [2:0] MOP_USQ = 3'd0;
    localparam logic [2:0] MOP_H1  = 3'd1;
    localparam logic [2:0] MOP_H2  = 3'd2;
    localparam logic [2:0] MOP_H3  = 3'd3;
    localparam logic [2:0] MOP_H4  = 3'd4;
    localparam logic [2:0] MOP_SIN = 3'd5;
    localparam logic [2:0] MOP_SQR = 3'd6;
    localparam logic [2:0] MOP_ACC = 3'd7;

    typedef enum logic [12:0] {
        ST_IDLE       = 13'b0000000000001,
        ST_SETUP      = 13'b0000000000010,  // clamp factor and grain, n*factor
        ST_LENGTH     = 13'b0000000000100,  // output length from product
        ST_CHECK      = 13'b0000000001000,  // past end / short input / stretch
        ST_SHORT_DATA = 13'b0000000010000,
        ST_GRAIN      = 13'b0000000100000,  // set up one covering grain
        ST_DIV_START  = 13'b0000001000000,  // grain input start
        ST_UDIV_LOAD  = 13'b0000010000000,  // take sample, start phase divide
        ST_UDIV       = 13'b0000100000000,  // window phase u
        ST_MUL        = 13'b0001000000000,  // shared multiplier sequence
        ST_NEXT       = 13'b0010000000000,
        ST_FINAL      = 13'b0100000000000,  // round and saturate
        ST_EMIT       = 13'b1000000000000   // hand result to output register
    } state_t;

    // control state
    state_t                  state_reg, state_next;
    logic [FACTOR_W-1:0]     stretch_reg, stretch_next;
    logic [FACTOR_W-1:0]     factor_reg, factor_next;     // factor latched for the run
    logic [NW-1:0]           count_reg, count_next;       // samples loaded
    logic [PW-1:0]           pos_reg, pos_next;           // read position
    logic [PW-1:0]           len_reg, len_next;           // output length
    logic [GW-1:0]           grain_reg, grain_next;
    logic [PW-1:0]           k_reg, k_next;               // newest grain covering pos
    logic [GW-1:0]           r_reg, r_next;               // pos - k*hop
    logic [PW-1:0]           base_reg, base_next;         // k*hop
    logic [1:0]              j_reg, j_next;               // grain offset back from k
    logic [3:0]              mstep_reg, mstep_next;
    logic [CW-1:0]           div_cnt_reg, div_cnt_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // datapath
    logic [GW-1:0]           i_reg, i_next;
    logic                    si_ok_reg, si_ok_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [DNW-1:0]          div_quo_reg, div_quo_next;
    logic [DDW-1:0]          div_den_reg, div_den_next;
    logic [DDW-1:0]          div_rem_reg, div_rem_next;
    logic [U_W-1:0]          u_reg, u_next;
    logic [U_W-1:0]          u2_reg, u2_next;
    logic signed [MA_W-1:0]  p_reg, p_next;
    logic [WIN_W-1:0]        s15_reg, s15_next;
    logic [WIN_W-1:0]        w_reg, w_next;
    logic signed [MP_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [SAMPLE_W-1:0]     res_sample_reg, res_sample_next;
    logic                    res_last_reg, res_last_next;
    logic                    res_past_reg, res_past_next;
    logic [SAMPLE_W-1:0]     out_sample_reg, out_sample_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_past_reg, out_past_next;

    // sample store port
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [SAMPLE_W-1:0]     ram_rdata;

    // helpers
    logic [NW-1:0]           cnt_eff;
    logic [GW-1:0]           hop;
    logic [GW-1:0]           span;
    logic [GW:0]             j_hop, jn_hop;
    logic [1:0]              j_inc;
    logic [GW:0]             i_calc, i_nx;
    logic [PW-1:0]           start_calc;
    logic [GW-1:0]           d_calc;
    logic [FACTOR_W-1:0]     factor_clamp;
    logic [31:0]             g_wide;
    logic [DDW:0]            rem_sh;
    logic                    div_ge;
    logic [DDW:0]            rem_sub;
    logic                    div_done;
    logic [DNW:0]            si;
    logic [2:0]              mop;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  prod_bias;
    logic signed [TW-1:0]    t16;
    logic [S_W-1:0]          s_cl;
    logic [MP_W-1:0]         len_sum;
    logic [PW-1:0]           len_raw;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] acc_q;
    logic [SAMPLE_W-1:0]     sat_out;
    logic                    s_xfer;

    ots_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_sample_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_past_reg;

    // a load after a read-out starts a new channel
    assign cnt_eff = (pos_reg != '0) ? '0 : count_reg;

    assign hop  = grain_reg >> 1;
    assign span = grain_reg - GW'(1);

    // grains covering pos are k, k-1 and (odd grain size only) k-2
    assign j_hop  = (j_reg == 2'd2) ? {hop, 1'b0} :
                    (j_reg == 2'd1) ? {1'b0, hop} : '0;
    assign j_inc  = j_reg + 2'd1;
    assign jn_hop = (j_inc == 2'd2) ? {hop, 1'b0} : {1'b0, hop};
    assign i_calc = {1'b0, r_reg} + j_hop;
    assign i_nx   = {1'b0, r_reg} + jn_hop;
    assign start_calc = base_reg - PW'(j_hop);
    assign d_calc = (i_reg < (span - i_reg)) ? i_reg : (span - i_reg);

    assign factor_clamp = (32'(stretch_reg) < FACTOR_LO) ? FACTOR_W'(FACTOR_LO) :
                          (32'(stretch_reg) > FACTOR_HI) ? FACTOR_W'(FACTOR_HI) :
                          stretch_reg;

    always_comb
    begin
        g_wide = 32'(count_reg >> 3);
        if (g_wide < GRAIN_MIN)
        begin
            g_wide = GRAIN_MIN;
        end
        if (g_wide > GRAIN_MAX)
        begin
            g_wide = GRAIN_MAX;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign rem_sh   = {div_rem_reg, div_quo_reg[DNW-1]};
    assign div_ge   = (rem_sh >= {1'b0, div_den_reg});
    assign rem_sub  = rem_sh - {1'b0, div_den_reg};
    assign div_done = (div_cnt_reg == CW'(DNW));

    assign si = {1'b0, div_quo_reg} + (DNW + 1)'(i_reg);

    // shared multiplier
    assign mop = mstep_reg[3:1];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_SETUP)
        begin
            mul_a = $signed(MA_W'(count_reg));
            mul_b = $signed(MB_W'(factor_clamp));
        end
        else
        begin
            case (mop)
                MOP_USQ:
                begin
                    mul_a = $signed(MA_W'(u_reg));
                    mul_b = $signed(MB_W'(u_reg));
                end
                MOP_H1, MOP_H2, MOP_H3, MOP_H4:
                begin
                    mul_a = p_reg;
                    mul_b = $signed(MB_W'(u2_reg));
                end
                MOP_SIN:
                begin
                    mul_a = p_reg;
                    mul_b = $signed(MB_W'(u_reg));
                end
                MOP_SQR:
                begin
                    mul_a = $signed(MA_W'(s15_reg));
                    mul_b = $signed(MB_W'(s15_reg));
                end
                MOP_ACC:
                begin
                    mul_a = MA_W'(sample_reg);
                    mul_b = $signed(MB_W'(w_reg));
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign prod_next = mul_a * mul_b;

    // product / 65536 truncated toward zero
    assign prod_bias = prod_reg + (prod_reg[MP_W-1] ? MP_W'(TRUNC_BIAS) : MP_W'(0));
    assign t16       = prod_bias[MP_W-1:Q16];

    always_comb
    begin
        if (t16 < 0)
        begin
            s_cl = '0;
        end
        else if (t16 > TW'(S_MAX))
        begin
            s_cl = S_W'(S_MAX);
        end
        else
        begin
            s_cl = t16[S_W-1:0];
        end
    end

    assign len_sum = prod_reg + MP_W'(ROUND_LEN);
    assign len_raw = len_sum[PW+LEN_SHIFT-1:LEN_SHIFT];

    assign acc_sum = acc_reg + ACC_W'(ROUND_OUT);
    assign acc_q   = acc_sum >>> OUT_SHIFT;
    assign sat_out = (acc_q > ACC_W'(OUT_MAX)) ? SAMPLE_W'(OUT_MAX) :
                     (acc_q < ACC_W'(OUT_MIN)) ? SAMPLE_W'(OUT_MIN) :
                     acc_q[SAMPLE_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        stretch_next    = stretch_reg;
        factor_next     = factor_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        grain_next      = grain_reg;
        k_next          = k_reg;
        r_next          = r_reg;
        base_next       = base_reg;
        j_next          = j_reg;
        mstep_next      = mstep_reg;
        div_cnt_next    = div_cnt_reg;
        m_tvalid_next   = m_tvalid_reg;
        i_next          = i_reg;
        si_ok_next      = si_ok_reg;
        sample_next     = sample_reg;
        div_quo_next    = div_quo_reg;
        div_den_next    = div_den_reg;
        div_rem_next    = div_rem_reg;
        u_next          = u_reg;
        u2_next         = u2_reg;
        p_next          = p_reg;
        s15_next        = s15_reg;
        w_next          = w_reg;
        acc_next        = acc_reg;
        res_sample_next = res_sample_reg;
        res_last_next   = res_last_reg;
        res_past_next   = res_past_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        out_past_next   = out_past_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_eff[AW-1:0];
        ram_raddr       = si[AW-1:0];

        if (cfg_valid)
        begin
            stretch_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    case (opcode_t'(s_tuser))
                        OP_LOAD:
                        begin
                            pos_next = '0;
                            if (cnt_eff < NW'(MAX_SAMPLES))
                            begin
                                ram_we     = 1'b1;
                                count_next = cnt_eff + NW'(1);
                            end
                            else
                            begin
                                count_next = cnt_eff;
                            end
                        end
                        OP_RESTART:
                        begin
                            pos_next = '0;
                        end
                        OP_READ:
                        begin
                            state_next = (pos_reg == '0) ? ST_SETUP : ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                factor_next = factor_clamp;
                grain_next  = GW'(g_wide);
                k_next      = '0;
                r_next      = '0;
                base_next   = '0;
                state_next  = ST_LENGTH;
            end
            ST_LENGTH:
            begin
                if (count_reg < NW'(MIN_OUT))
                begin
                    len_next = PW'(count_reg);
                end
                else if (len_raw < PW'(MIN_OUT))
                begin
                    len_next = PW'(MIN_OUT);
                end
                else
                begin
                    len_next = len_raw;
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                ram_raddr = pos_reg[AW-1:0];
                if (pos_reg >= len_reg)
                begin
                    res_sample_next = '0;
                    res_last_next   = 1'b0;
                    res_past_next   = 1'b1;
                    state_next      = ST_EMIT;
                end
                else if (count_reg < NW'(MIN_OUT))
                begin
                    state_next = ST_SHORT_DATA;
                end
                else
                begin
                    acc_next   = '0;
                    j_next     = '0;
                    state_next = ST_GRAIN;
                end
            end
            ST_GRAIN:
            begin
                i_next       = i_calc[GW-1:0];
                div_quo_next = (DNW'(start_calc) << START_SHIFT) + DNW'(factor_reg);
                div_den_next = {factor_reg, 1'b0};
                div_rem_next = '0;
                div_cnt_next = '0;
                state_next   = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                if (!div_done)
                begin
                    div_rem_next = div_ge ? rem_sub[DDW-1:0] : rem_sh[DDW-1:0];
                    div_quo_next = {div_quo_reg[DNW-2:0], div_ge};
                    div_cnt_next = div_cnt_reg + CW'(1);
                end
                else
                begin
                    // quotient ready: read the grain's input sample
                    si_ok_next = (si < (DNW + 1)'(count_reg));
                    state_next = ST_UDIV_LOAD;
                end
            end
            ST_UDIV_LOAD:
            begin
                sample_next  = ram_rdata;
                div_quo_next = DNW'(d_calc) << U_SHIFT;
                div_den_next = DDW'(span);
                div_rem_next = '0;
                div_cnt_next = '0;
                state_next   = ST_UDIV;
            end
            ST_UDIV:
            begin
                if (!div_done)
                begin
                    div_rem_next = div_ge ? rem_sub[DDW-1:0] : rem_sh[DDW-1:0];
                    div_quo_next = {div_quo_reg[DNW-2:0], div_ge};
                    div_cnt_next = div_cnt_reg + CW'(1);
                end
                else
                begin
                    u_next     = div_quo_reg[U_W-1:0];
                    mstep_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // even step: product registered; odd step: result folded back
                mstep_next = mstep_reg + 4'd1;
                if (mstep_reg[0])
                begin
                    case (mop)
                        MOP_USQ:
                        begin
                            u2_next = prod_reg[Q16+U_W-1:Q16];
                            p_next  = MA_W'(HC0);
                        end
                        MOP_H1, MOP_H2, MOP_H3, MOP_H4:
                        begin
                            p_next = horner_coef(mop) + t16[MA_W-1:0];
                        end
                        MOP_SIN:
                        begin
                            s15_next = WIN_W'((s_cl + S_W'(ROUND_S)) >> S15_SHIFT);
                        end
                        MOP_SQR:
                        begin
                            w_next = WIN_W'((prod_reg + MP_W'(ROUND_W)) >>> W_SHIFT);
                        end
                        MOP_ACC:
                        begin
                            if (si_ok_reg)
                            begin
                                acc_next = acc_reg + ACC_W'(prod_reg);
                            end
                            state_next = ST_NEXT;
                        end
                        default:
                        begin
                            state_next = ST_NEXT;
                        end
                    endcase
                end
            end
            ST_NEXT:
            begin
                if ((j_reg != 2'd2) && (k_reg >= PW'(j_inc)) && (i_nx < {1'b0, grain_reg}))
                begin
                    j_next     = j_inc;
                    state_next = ST_GRAIN;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL, ST_SHORT_DATA:
            begin
                res_sample_next = (state_reg == ST_FINAL) ? sat_out : ram_rdata;
                res_last_next   = (pos_reg == (len_reg - PW'(1)));
                res_past_next   = 1'b0;
                pos_next        = pos_reg + PW'(1);
                if ((r_reg + GW'(1)) == hop)
                begin
                    r_next    = '0;
                    k_next    = k_reg + PW'(1);
                    base_next = base_reg + PW'(hop);
                end
                else
                begin
                    r_next = r_reg + GW'(1);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_sample_next = res_sample_reg;
                    out_last_next   = res_last_reg;
                    out_past_next   = res_past_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            stretch_reg  <= FACTOR_W'(FACTOR_RESET);
            factor_reg   <= FACTOR_W'(FACTOR_RESET);
            count_reg    <= '0;
            pos_reg      <= '0;
            len_reg      <= '0;
            grain_reg    <= GW'(GRAIN_MIN);
            k_reg        <= '0;
            r_reg        <= '0;
            base_reg     <= '0;
            j_reg        <= '0;
            mstep_reg    <= '0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            stretch_reg  <= stretch_next;
            factor_reg   <= factor_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            grain_reg    <= grain_next;
            k_reg        <= k_next;
            r_reg        <= r_next;
            base_reg     <= base_next;
            j_reg        <= j_next;
            mstep_reg    <= mstep_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        si_ok_reg      <= si_ok_next;
        sample_reg     <= sample_next;
        div_quo_reg    <= div_quo_next;
        div_den_reg    <= div_den_next;
        div_rem_reg    <= div_rem_next;
        u_reg          <= u_next;
        u2_reg         <= u2_next;
        p_reg          <= p_next;
        s15_reg        <= s15_next;
        w_reg          <= w_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        res_sample_reg <= res_sample_next;
        res_last_reg   <= res_last_next;
        res_past_reg   <= res_past_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
        out_past_reg   <= out_past_next;
    end

    // checks
    `OTS_ASSERT_IMPLY(a_pos_in_range, 1'b1, pos_reg <= len_reg, "read position beyond output length")
    `OTS_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= NW'(MAX_SAMPLES), "loaded count overflow")
    `OTS_ASSERT_IMPLY(a_past_end_zero, m_tvalid && m_tuser, (m_tdata == '0) && !m_tlast, "past-end result not zero")
    `OTS_ASSERT_NEXT(a_read_busy, s_xfer && (s_tuser == OP_READ), !s_tready, "read did not start work")

endmodule

`default_nettype wire

/* sv/ots_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module ots_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
